### hw/rtl/ksv_pkg.sv
`default_nettype none
package ksv_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FREQ_W     = 24;
  localparam int RATE_W     = 18;
  // dividend is sample_rate * 512
  localparam int DIVIDEND_W = RATE_W + 9;

  localparam logic [RATE_W-1:0]   RATE_RESET = 18'd48000;
  localparam logic [SAMPLE_W-1:0] LFSR_SEED  = 16'hACE1;
  localparam logic [SAMPLE_W-1:0] LFSR_TAPS  = 16'hB400;
  localparam logic [SAMPLE_W:0]   DAMP_Q16   = 17'd32571;

  localparam logic REQ_RENDER = 1'b0;
  localparam logic REQ_PLUCK  = 1'b1;

  function automatic logic [SAMPLE_W-1:0] lfsr_next(input logic [SAMPLE_W-1:0] s);
    logic [SAMPLE_W-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LFSR_TAPS;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/plucked_string_synth_voice.sv
`default_nettype none
// Render: the voice steps READ, MUL, EMIT and raises m_tvalid in EMIT, then returns to IDLE
//   (straight to EMIT before the first pluck); a held m_* beat stalls the write back.
// Pluck: 27 divider steps, then loop_length fill writes (one memory write a cycle);
//   zero frequency skips the divider. No result beat. New requests are taken only in IDLE.
// Reset (rst, synchronous): position 0, loop length 1, LFSR 0xACE1, not plucked,
//   sample_rate 48000. Delay memory holds garbage until a pluck fills it.
module plucked_string_synth_voice
  import ksv_pkg::*;
#(
  parameter int DEPTH = 8192
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // slave side: tdata = frequency_q8[23:0]; tuser = req_type[0]
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [FREQ_W-1:0]   s_tdata,
  input  wire logic [0:0]          s_tuser,
  // master side: tdata = sample[15:0]
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [SAMPLE_W-1:0]      m_tdata,
  // sample_rate register write
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [RATE_W-1:0]   cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_FILL = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam logic [DIVIDEND_W:0] DEPTH_Q = (DIVIDEND_W + 1)'(DEPTH);

  logic [2:0]            state;
  logic [RATE_W-1:0]     sample_rate;
  logic [AW-1:0]         pos;
  logic [LW-1:0]         loop_length;
  logic [LW-1:0]         fill_idx;
  logic [SAMPLE_W-1:0]   lfsr;
  logic                  primed;
  logic                  out_free;

  // divider
  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quot;

  // delay memory
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [SAMPLE_W-1:0]   mem_wdata;
  logic [AW-1:0]         prev_addr;
  logic [SAMPLE_W-1:0]   cur_q;
  logic [SAMPLE_W-1:0]   prev_q;

  // damping datapath
  logic signed [SAMPLE_W:0]     sum;
  logic signed [SAMPLE_W:0]     damp_k;
  logic signed [2*SAMPLE_W+1:0] prod;
  logic [SAMPLE_W-1:0]          damped;
  logic [SAMPLE_W-1:0]          lfsr_step;
  logic [LW-1:0]                len_from_q;
  logic [LW-1:0]                pos_inc;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // the entry before position 0 is the last one of the loop
  assign prev_addr = (pos == '0) ? AW'(loop_length - 1'b1) : pos - 1'b1;

  // sum of two Q1.15 values, scaled by 0.497; floor keeps it inside Q1.15
  assign damp_k = $signed(DAMP_Q16);
  assign sum    = $signed({cur_q[SAMPLE_W-1], cur_q}) + $signed({prev_q[SAMPLE_W-1], prev_q});
  assign damped = prod[2*SAMPLE_W-1:SAMPLE_W];

  assign lfsr_step = lfsr_next(lfsr);
  assign pos_inc   = LW'(pos) + 1'b1;

  // loop length = floor(2*rate/freq) + 1, saturating at DEPTH
  assign len_from_q = ({1'b0, div_quot} >= DEPTH_Q) ? LW'(DEPTH) : LW'(div_quot) + 1'b1;

  assign div_start = s_tvalid && s_tready && (s_tuser[0] == REQ_PLUCK) && (s_tdata != '0);

  assign mem_we    = (state == ST_FILL) || (state == ST_EMIT && primed && out_free);
  assign mem_waddr = (state == ST_FILL) ? fill_idx[AW-1:0] : pos;
  assign mem_wdata = (state == ST_FILL) ? lfsr_step : damped;

  ksv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sample_rate, 9'b0}),
    .divisor  (s_tdata),
    .done     (div_done),
    .quotient (div_quot)
  );

  ksv_dline #(.DEPTH(DEPTH)) u_dline (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (pos),
    .raddr_b (prev_addr),
    .rdata_a (cur_q),
    .rdata_b (prev_q)
  );

  // hold the sample rate; the divider takes a copy when a pluck starts
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      sample_rate <= cfg_data;
    end
  end

  // register the damping product between the memory read and the write back
  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      prod <= sum * damp_k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos         <= '0;
      loop_length <= LW'(1);
      lfsr        <= LFSR_SEED;
      primed      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      // drop the result once the beat is taken; EMIT reloads it itself
      if (m_tvalid && m_tready && (state != ST_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser[0] == REQ_PLUCK) begin
              if (s_tdata == '0) begin
                loop_length <= LW'(DEPTH);
                fill_idx    <= '0;
                state       <= ST_FILL;
              end else begin
                state <= ST_DIV;
              end
            end else if (primed) begin
              state <= ST_READ;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            loop_length <= len_from_q;
            fill_idx    <= '0;
            state       <= ST_FILL;
          end
        end
        ST_FILL: begin
          // one noise entry a cycle
          lfsr     <= lfsr_step;
          fill_idx <= fill_idx + 1'b1;
          if (fill_idx == loop_length - 1'b1) begin
            pos    <= '0;
            primed <= 1'b1;
            state  <= ST_IDLE;
          end
        end
        ST_READ: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // wait for the output register, then emit; once plucked, also write back and advance
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= primed ? damped : '0;
            if (primed) begin
              pos <= (pos_inc == loop_length) ? '0 : AW'(pos_inc);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ksv_div.sv
`default_nettype none
module ksv_div
  import ksv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [FREQ_W-1:0]     divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [DIVIDEND_W-1:0] work;
  logic [FREQ_W-1:0]     rem;
  logic [FREQ_W-1:0]     dvs;
  logic [CNT_W-1:0]      count;
  logic                  busy;
  logic [FREQ_W:0]       trial;
  logic [FREQ_W:0]       diff;
  logic                  fits;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem, work[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = !diff[FREQ_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        rem   <= '0;
        work  <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= fits ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
        work  <= {work[DIVIDEND_W-2:0], fits};
        count <= count + 1'b1;
        if (count == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = work;

endmodule
`default_nettype wire

### hw/rtl/ksv_dline.sv
`default_nettype none
module ksv_dline
  import ksv_pkg::*;
#(
  parameter int DEPTH = 8192
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [SAMPLE_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
  output logic [SAMPLE_W-1:0]             rdata_a,
  output logic [SAMPLE_W-1:0]             rdata_b
);

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

### bench/ksv_sample_checker.sv
`timescale 1ns / 1ps
module ksv_sample_checker
  import ksv_pkg::*;
#(
  parameter int DEPTH = 8192
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  input  wire logic                s_tready,
  input  wire logic [FREQ_W-1:0]   s_tdata,
  input  wire logic [0:0]          s_tuser,
  input  wire logic                m_tvalid,
  input  wire logic                m_tready,
  input  wire logic [SAMPLE_W-1:0] m_tdata,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [RATE_W-1:0]   cfg_data,
  input  wire logic                drain_done,
  output int                       pending,
  output int                       fail_count,
  output int                       checked_count
);

  localparam int MAX_LINES = 100;

  // predicted voice state
  logic [SAMPLE_W-1:0]        string_mem [DEPTH];
  int unsigned                read_pos;
  int unsigned                loop_len;
  logic [SAMPLE_W-1:0]        noise;
  bit                         plucked;
  logic [RATE_W-1:0]          rate;
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  bit                         drained;

  initial begin
    pending       = 0;
    fail_count    = 0;
    checked_count = 0;
    drained       = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_LINES) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    fail_count++;
  endtask

  function automatic int unsigned loop_len_for(input logic [FREQ_W-1:0] freq);
    logic [63:0] q;
    if (freq == '0) begin
      return DEPTH;
    end
    q = (64'(rate) << 9) / 64'(freq);
    if (q >= 64'(DEPTH)) begin
      return DEPTH;
    end
    return q[31:0] + 1;
  endfunction

  function automatic void pluck_string(input logic [FREQ_W-1:0] freq);
    int unsigned i;
    loop_len = loop_len_for(freq);
    read_pos = 0;
    for (i = 0; i < loop_len; i++) begin
      noise = {1'b0, noise[SAMPLE_W-1:1]} ^ (noise[0] ? LFSR_TAPS : '0);
      string_mem[i] = noise;
    end
    plucked = 1'b1;
  endfunction

  // sum with the previous tap, scale by 0.497, write back, advance; silence before any pluck
  function automatic logic signed [SAMPLE_W-1:0] render_sample();
    int unsigned         prev;
    logic signed [16:0]  sum;
    longint              scaled;
    if (!plucked) begin
      return '0;
    end
    prev   = (read_pos == 0) ? loop_len - 1 : read_pos - 1;
    sum    = $signed(string_mem[read_pos]) + $signed(string_mem[prev]);
    scaled = (longint'(sum) * longint'(DAMP_Q16)) >>> 16;
    string_mem[read_pos] = scaled[SAMPLE_W-1:0];
    read_pos = (read_pos + 1) % loop_len;
    return scaled[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    logic signed [SAMPLE_W-1:0] want;
    if (rst) begin
      read_pos = 0;
      loop_len = 1;
      noise    = LFSR_SEED;
      plucked  = 1'b0;
      rate     = RATE_RESET;
      expected_samples.delete();
    end else begin
      // compare output first so a sample can never match its own request beat
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("sample %0d with nothing expected", $signed(m_tdata)));
        end else begin
          want = expected_samples.pop_front();
          checked_count++;
          if (m_tdata !== want) begin
            report_mismatch($sformatf("sample: got %0d, want %0d", $signed(m_tdata), want));
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        rate = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == REQ_PLUCK) begin
          pluck_string(s_tdata);
        end else begin
          expected_samples.push_back(render_sample());
        end
      end
      if (drain_done && !drained) begin
        drained = 1'b1;
        foreach (expected_samples[i]) begin
          report_mismatch($sformatf("sample %0d never arrived", expected_samples[i]));
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

### bench/tb_plucked_string_synth_voice.sv
`timescale 1ns / 1ps
module tb_plucked_string_synth_voice;
  import ksv_pkg::*;

  localparam int DEPTH       = 8192;
  // worst pluck: divider steps plus a full fill of the delay line
  localparam int FILL_WAIT   = DEPTH + 64;
  localparam int HOLD_CYCLES = 500;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 146;
  // every item a full-depth pluck with stalls, several times over
  localparam int CYCLE_LIMIT = 4 * (NUM_PHASES * PHASE_ITEMS + 64) * (FILL_WAIT + 128);

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [FREQ_W-1:0]   s_tdata   = '0;   // frequency_q8[23:0]
  logic [0:0]          s_tuser   = '0;   // req_type[0]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;          // sample[15:0]
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RATE_W-1:0]   cfg_data  = '0;
  logic                drain_done = 1'b0;
  logic                long_hold  = 1'b0;
  logic                squeeze_go = 1'b0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int plucks         = 0;
  int renders        = 0;
  int cycles         = 0;
  int pending;
  int fail_count;
  int checked_count;

  plucked_string_synth_voice #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  ksv_sample_checker #(.DEPTH(DEPTH)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .drain_done   (drain_done),
    .pending      (pending),
    .fail_count   (fail_count),
    .checked_count(checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d samples outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall at the phase's rate, or hold off entirely while a squeeze runs.
  always @(posedge clk) begin
    if (long_hold) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Squeeze: hold the output off for a long stretch while the sender keeps
  // offering renders, so the voice backs up and drops s_tready.
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Offer one beat; ready is checked at the falling edge so the accepting
  // rising edge is known without racing the block's own updates.
  task automatic send_item(input logic req, input logic [FREQ_W-1:0] freq);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= freq;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    if (req == REQ_PLUCK) begin
      plucks++;
    end else begin
      renders++;
    end
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, wait for every sample, then let a trailing pluck finish its fill.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (FILL_WAIT) @(posedge clk);
  endtask

  // Mostly renders; plucks mostly aim at short loops so fills stay cheap,
  // with full-range and rare very low frequencies for long loops.
  task automatic random_item(input logic [RATE_W-1:0] rate);
    int unsigned       pick;
    int unsigned       span;
    logic [63:0]       aim;
    logic [FREQ_W-1:0] freq;
    pick = $urandom_range(99);
    if (pick >= 16) begin
      send_item(REQ_RENDER, FREQ_W'($urandom));
    end else begin
      if (pick < 11 && rate != '0) begin
        span = $urandom_range(48, 1);
        aim  = (64'(rate) << 9) / 64'(span);
        freq = (aim > 64'hFF_FFFF) ? 24'hFF_FFFF : aim[FREQ_W-1:0];
        freq = freq - FREQ_W'($urandom_range(freq >> 5, 0));
      end else if (pick == 15) begin
        freq = FREQ_W'($urandom_range(4095));
      end else begin
        freq = FREQ_W'($urandom);
      end
      send_item(REQ_PLUCK, freq);
    end
  endtask

  initial begin : stimulus
    logic [RATE_W-1:0] phase_rate [NUM_PHASES];
    logic [RATE_W-1:0] rate_min;
    logic [RATE_W-1:0] rate_max;
    int                p;
    int                n;

    // slowest and fastest audio rates, zero, all ones, a random one, back to default
    phase_rate[0] = 18'd8000;
    phase_rate[1] = 18'd192000;
    phase_rate[2] = '0;
    phase_rate[3] = '1;
    phase_rate[4] = RATE_W'($urandom_range(192000, 8000));
    phase_rate[5] = RATE_RESET;
    rate_min = '0;
    rate_max = '1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: renders before any pluck must give silence.
    send_item(REQ_RENDER, 24'hFF_FFFF);
    send_item(REQ_RENDER, '0);
    // zero frequency: full-depth loop
    send_item(REQ_PLUCK, '0);
    repeat (4) send_item(REQ_RENDER, '0);
    // top frequency: two-entry loop, wraps every other render
    send_item(REQ_PLUCK, 24'hFF_FFFF);
    repeat (4) send_item(REQ_RENDER, 24'hFF_FFFF);
    // lowest nonzero frequency saturates at full depth
    send_item(REQ_PLUCK, 24'h00_0001);
    repeat (3) send_item(REQ_RENDER, '0);
    send_item(REQ_PLUCK, 24'h80_0000);
    repeat (4) send_item(REQ_RENDER, '0);
    // back-to-back plucks, the second one wins
    send_item(REQ_PLUCK, 24'h55_5555);
    send_item(REQ_PLUCK, 24'hAA_AAAA);
    repeat (2) send_item(REQ_RENDER, '0);

    // Random phases, each under its own rate and one of four idling mixes.
    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_rate(phase_rate[p]);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 87;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 87;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      if (p == 0) begin
        squeeze_go <= 1'b1;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        random_item(phase_rate[p]);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle();
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Ran %0d plucks, %0d renders (%0d compared) at %0d rates, %0d to %0d Hz,",
             plucks, renders, checked_count, NUM_PHASES, rate_min, rate_max);
    $display("with sender gaps, receiver stalls and a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
